// File: design/assert_macros.svh
// Assertion macros used by the frame scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define BLS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (!(cond))) \
        else $error("%m: forbidden condition seen");
`else
`define BLS_ASSERT(lbl, clk, rst_n, prop)
`define BLS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: design/bls_pkg.sv
// Types, constants and the reciprocal table of the bilinear frame scaler.
`default_nettype none
package bls_pkg;

    localparam int MUL_W   = 5;   // scale multiplier and divisor
    localparam int DIM_W   = 13;  // destination size registers
    localparam int DST_W   = 12;  // destination coordinates
    localparam int SRC_W   = 8;   // source coordinates of a write
    localparam int RGB_W   = 24;
    localparam int CH_W    = 8;
    localparam int NX_W    = 17;  // destination coordinate times divisor
    localparam int CRD_W   = 18;  // source coordinate with room for the right neighbour
    localparam int RCP_W   = 24;
    localparam int RCP_SH  = 23;
    localparam int WGT_W   = 10;
    localparam int SUM_W   = 18;
    localparam int QUO_W   = 13;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic [MUL_W-1:0] RST_MULT  = 5'd2;
    localparam logic [MUL_W-1:0] RST_DIV   = 5'd1;
    localparam logic [DIM_W-1:0] RST_DST_W = 13'd512;
    localparam logic [DIM_W-1:0] RST_DST_H = 13'd480;

    typedef enum logic [1:0] {
        CFG_MULT  = 2'd0,
        CFG_DIV   = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic             kind;
        logic [SRC_W-1:0] src_col;
        logic [SRC_W-1:0] src_row;
        logic [RGB_W-1:0] src_rgb;
        logic [DST_W-1:0] dst_col;
        logic [DST_W-1:0] dst_row;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            out_of_range;
    } t_out_item;

    // Everything the blending stages need besides the four pixels.
    typedef struct packed {
        logic                       oor;
        logic                       x_par;
        logic                       y_par;
        logic [3:0]                 nb_ok;
        logic [3:0][WGT_W-1:0]      wgt;
        logic [RCP_W-1:0]           rcp;
    } t_blend_ctl;

    // Address bits that one parity bank needs along a source dimension.
    function automatic int bank_bits(input int n);
        return ($clog2(n) < 2) ? 1 : $clog2(n) - 1;
    endfunction

    // ceil(2^23 / m); a zero multiplier counts as one.
    function automatic logic [RCP_W-1:0] recip(input logic [MUL_W-1:0] m);
        logic [RCP_W-1:0] r;
        unique case (m)
            5'd2:    r = 24'd4194304;
            5'd3:    r = 24'd2796203;
            5'd4:    r = 24'd2097152;
            5'd5:    r = 24'd1677722;
            5'd6:    r = 24'd1398102;
            5'd7:    r = 24'd1198373;
            5'd8:    r = 24'd1048576;
            5'd9:    r = 24'd932068;
            5'd10:   r = 24'd838861;
            5'd11:   r = 24'd762601;
            5'd12:   r = 24'd699051;
            5'd13:   r = 24'd645278;
            5'd14:   r = 24'd599187;
            5'd15:   r = 24'd559241;
            5'd16:   r = 24'd524288;
            5'd17:   r = 24'd493448;
            5'd18:   r = 24'd466034;
            5'd19:   r = 24'd441506;
            5'd20:   r = 24'd419431;
            5'd21:   r = 24'd399458;
            5'd22:   r = 24'd381301;
            5'd23:   r = 24'd364723;
            5'd24:   r = 24'd349526;
            5'd25:   r = 24'd335545;
            5'd26:   r = 24'd322639;
            5'd27:   r = 24'd310690;
            5'd28:   r = 24'd299594;
            5'd29:   r = 24'd289263;
            5'd30:   r = 24'd279621;
            5'd31:   r = 24'd270601;
            default: r = 24'd8388608;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/bls_ram.sv
// One parity bank of the source frame store, one write and one registered read port.
`default_nettype none
module bls_ram #(
    parameter int AW = 14,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1 << AW) - 1];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/bls_coord.sv
// Source position, fraction, weights and bank addresses: three pipeline stages.
`default_nettype none
module bls_coord #(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 256,
    localparam int CB = bls_pkg::bank_bits(SRC_WIDTH),
    localparam int RB = bls_pkg::bank_bits(SRC_HEIGHT),
    localparam int AW = CB + RB
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bls_pkg::t_in_item             i_data,
    input  logic [bls_pkg::MUL_W-1:0]     i_mult,
    input  logic [bls_pkg::MUL_W-1:0]     i_div,
    input  logic [bls_pkg::DIM_W-1:0]     i_dst_w,
    input  logic [bls_pkg::DIM_W-1:0]     i_dst_h,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bls_pkg::t_blend_ctl           o_ctl,
    output logic [3:0][AW-1:0]            o_rd_addr,
    output logic                          o_wr_en,
    output logic [1:0]                    o_wr_bank,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [bls_pkg::RGB_W-1:0]     o_wr_data
);
    import bls_pkg::*;

    localparam logic [CRD_W-1:0] LIM_X = CRD_W'(SRC_WIDTH);
    localparam logic [CRD_W-1:0] LIM_Y = CRD_W'(SRC_HEIGHT);

    logic rdy_a, rdy_b, rdy_c, adv_c;
    logic r_v_a, r_v_b, r_v_c;

    // Stage A: ratio products and destination checks.
    logic [MUL_W-1:0] n_m, n_d;
    logic [NX_W-1:0]  n_nx, n_ny;
    logic             n_oor, n_lastc, n_lastr;

    logic             r_a_kind, r_a_oor, r_a_lastc, r_a_lastr;
    logic [NX_W-1:0]  r_a_nx, r_a_ny;
    logic [MUL_W-1:0] r_a_m;
    logic [RCP_W-1:0] r_a_rcp;
    logic [SRC_W-1:0] r_a_col, r_a_row;
    logic [RGB_W-1:0] r_a_rgb;

    always_comb begin
        n_m     = (i_mult == '0) ? MUL_W'(1) : i_mult;
        n_d     = (i_div == '0) ? MUL_W'(1) : i_div;
        n_nx    = NX_W'(i_data.dst_col) * NX_W'(n_d);
        n_ny    = NX_W'(i_data.dst_row) * NX_W'(n_d);
        n_oor   = (DIM_W'(i_data.dst_col) >= i_dst_w) || (DIM_W'(i_data.dst_row) >= i_dst_h);
        n_lastc = (DIM_W'(i_data.dst_col) + DIM_W'(1)) == i_dst_w;
        n_lastr = (DIM_W'(i_data.dst_row) + DIM_W'(1)) == i_dst_h;
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_kind  <= i_data.kind;
            r_a_oor   <= n_oor;
            r_a_lastc <= n_lastc;
            r_a_lastr <= n_lastr;
            r_a_nx    <= n_nx;
            r_a_ny    <= n_ny;
            r_a_m     <= n_m;
            r_a_rcp   <= recip(n_m);
            r_a_col   <= i_data.src_col;
            r_a_row   <= i_data.src_row;
            r_a_rgb   <= i_data.src_rgb;
        end
    end

    // Stage B: quotient by reciprocal multiplication.
    logic [NX_W+RCP_W-1:0] n_px, n_py;
    logic                  r_b_kind, r_b_oor, r_b_lastc, r_b_lastr;
    logic [NX_W-1:0]       r_b_qx, r_b_qy, r_b_nx, r_b_ny;
    logic [MUL_W-1:0]      r_b_m;
    logic [RCP_W-1:0]      r_b_rcp;
    logic [SRC_W-1:0]      r_b_col, r_b_row;
    logic [RGB_W-1:0]      r_b_rgb;

    always_comb begin
        n_px = (NX_W+RCP_W)'(r_a_nx) * (NX_W+RCP_W)'(r_a_rcp);
        n_py = (NX_W+RCP_W)'(r_a_ny) * (NX_W+RCP_W)'(r_a_rcp);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_kind  <= r_a_kind;
            r_b_oor   <= r_a_oor;
            r_b_lastc <= r_a_lastc;
            r_b_lastr <= r_a_lastr;
            r_b_qx    <= n_px[RCP_SH +: NX_W];
            r_b_qy    <= n_py[RCP_SH +: NX_W];
            r_b_nx    <= r_a_nx;
            r_b_ny    <= r_a_ny;
            r_b_m     <= r_a_m;
            r_b_rcp   <= r_a_rcp;
            r_b_col   <= r_a_col;
            r_b_row   <= r_a_row;
            r_b_rgb   <= r_a_rgb;
        end
    end

    // Stage C: remainders give the fractions.
    logic [NX_W+MUL_W-1:0] n_mx, n_my;
    logic [NX_W-1:0]       n_rx, n_ry;
    logic                  r_c_kind, r_c_oor, r_c_lastc, r_c_lastr;
    logic [NX_W-1:0]       r_c_qx, r_c_qy;
    logic [MUL_W-1:0]      r_c_fx, r_c_fy, r_c_m;
    logic [RCP_W-1:0]      r_c_rcp;
    logic [SRC_W-1:0]      r_c_col, r_c_row;
    logic [RGB_W-1:0]      r_c_rgb;

    always_comb begin
        n_mx = (NX_W+MUL_W)'(r_b_qx) * (NX_W+MUL_W)'(r_b_m);
        n_my = (NX_W+MUL_W)'(r_b_qy) * (NX_W+MUL_W)'(r_b_m);
        n_rx = r_b_nx - n_mx[NX_W-1:0];
        n_ry = r_b_ny - n_my[NX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_kind  <= r_b_kind;
            r_c_oor   <= r_b_oor;
            r_c_lastc <= r_b_lastc;
            r_c_lastr <= r_b_lastr;
            r_c_qx    <= r_b_qx;
            r_c_qy    <= r_b_qy;
            r_c_fx    <= n_rx[MUL_W-1:0];
            r_c_fy    <= n_ry[MUL_W-1:0];
            r_c_m     <= r_b_m;
            r_c_rcp   <= r_b_rcp;
            r_c_col   <= r_b_col;
            r_c_row   <= r_b_row;
            r_c_rgb   <= r_b_rgb;
        end
    end

    // Handshake along the three stages; a write leaves stage C without waiting.
    assign adv_c   = r_v_c && ((r_c_kind == KIND_WRITE) || i_ready);
    assign rdy_c   = !r_v_c || adv_c;
    assign rdy_b   = !r_v_b || rdy_c;
    assign rdy_a   = !r_v_a || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_v_c && (r_c_kind == KIND_COMPUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
        end else begin
            if (rdy_a) r_v_a <= i_valid;
            if (rdy_b) r_v_b <= r_v_a;
            if (rdy_c) r_v_c <= r_v_b;
        end
    end

    // Neighbours, weights and bank addresses from stage C.
    logic [CRD_W-1:0]      xb, yb, x1, y1;
    logic [1:0][CRD_W-1:0] col_p, row_p;
    logic [MUL_W-1:0]      wl, wr, wt, wb;
    logic                  ok_x0, ok_x1, ok_y0, ok_y1;
    logic [CRD_W-1:0]      wcol, wrow;

    always_comb begin
        xb    = CRD_W'(r_c_qx);
        yb    = CRD_W'(r_c_qy);
        x1    = xb + CRD_W'(1);
        y1    = yb + CRD_W'(1);
        // Bank of parity p holds whichever of the two neighbours has that parity.
        col_p[0] = xb[0] ? x1 : xb;
        col_p[1] = xb[0] ? xb : x1;
        row_p[0] = yb[0] ? y1 : yb;
        row_p[1] = yb[0] ? yb : y1;
        ok_x0 = xb < LIM_X;
        ok_x1 = x1 < LIM_X;
        ok_y0 = yb < LIM_Y;
        ok_y1 = y1 < LIM_Y;
        wl = r_c_m - r_c_fx;
        wr = r_c_lastc ? '0 : r_c_fx;
        wt = r_c_m - r_c_fy;
        wb = r_c_lastr ? '0 : r_c_fy;
        o_ctl.oor    = r_c_oor;
        o_ctl.x_par  = xb[0];
        o_ctl.y_par  = yb[0];
        o_ctl.nb_ok  = {ok_x1 && ok_y1, ok_x0 && ok_y1, ok_x1 && ok_y0, ok_x0 && ok_y0};
        o_ctl.wgt[0] = WGT_W'(wl) * WGT_W'(wt);
        o_ctl.wgt[1] = WGT_W'(wr) * WGT_W'(wt);
        o_ctl.wgt[2] = WGT_W'(wl) * WGT_W'(wb);
        o_ctl.wgt[3] = WGT_W'(wr) * WGT_W'(wb);
        o_ctl.rcp    = r_c_rcp;
        for (int b = 0; b < 4; b++) begin
            o_rd_addr[b] = {row_p[b / 2][RB:1], col_p[b % 2][CB:1]};
        end
        wcol      = CRD_W'(r_c_col);
        wrow      = CRD_W'(r_c_row);
        o_wr_en   = r_v_c && (r_c_kind == KIND_WRITE) && (wcol < LIM_X) && (wrow < LIM_Y);
        o_wr_bank = {wrow[0], wcol[0]};
        o_wr_addr = {wrow[RB:1], wcol[CB:1]};
        o_wr_data = r_c_rgb;
    end

endmodule
`default_nettype wire

// File: design/bls_blend.sv
// Weighted sum of the four neighbours and the division by the squared multiplier.
`default_nettype none
`include "assert_macros.svh"
module bls_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bls_pkg::t_blend_ctl                i_ctl,
    input  logic [3:0][bls_pkg::RGB_W-1:0]     i_pix,
    output logic                               o_valid,
    input  logic                               i_ready,
    output bls_pkg::t_out_item                 o_data
);
    import bls_pkg::*;

    logic rdy_d, rdy_e, rdy_f, rdy_g;
    logic r_v_d, r_v_e, r_v_f, r_v_g;

    assign rdy_g   = !r_v_g || i_ready;
    assign rdy_f   = !r_v_f || rdy_g;
    assign rdy_e   = !r_v_e || rdy_f;
    assign rdy_d   = !r_v_d || rdy_e;
    assign o_ready = rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
            r_v_f <= 1'b0;
            r_v_g <= 1'b0;
        end else begin
            if (rdy_d) r_v_d <= i_valid;
            if (rdy_e) r_v_e <= r_v_d;
            if (rdy_f) r_v_f <= r_v_e;
            if (rdy_g) r_v_g <= r_v_f;
        end
    end

    // Stage D: control arrives with the bank read data.
    t_blend_ctl r_d_ctl;

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_ctl <= i_ctl;
        end
    end

    logic [3:0][RGB_W-1:0] nb;
    logic [2:0][SUM_W-1:0] n_sum;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nb[k] = r_d_ctl.nb_ok[k]
                  ? i_pix[{r_d_ctl.y_par ^ (k >= 2), r_d_ctl.x_par ^ (k % 2 == 1)}]
                  : '0;
        end
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = '0;
            for (int k = 0; k < 4; k++) begin
                n_sum[c] = n_sum[c]
                         + SUM_W'(nb[k][c*CH_W +: CH_W]) * SUM_W'(r_d_ctl.wgt[k]);
            end
        end
    end

    // Stage E: first division by the multiplier.
    logic [2:0][SUM_W-1:0] r_e_sum;
    logic                  r_e_oor;
    logic [RCP_W-1:0]      r_e_rcp;

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_e_sum <= n_sum;
            r_e_oor <= r_d_ctl.oor;
            r_e_rcp <= r_d_ctl.rcp;
        end
    end

    logic [2:0][SUM_W+RCP_W-1:0] n_pe;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_pe[c] = (SUM_W+RCP_W)'(r_e_sum[c]) * (SUM_W+RCP_W)'(r_e_rcp);
        end
    end

    // Stage F: second division by the multiplier.
    logic [2:0][QUO_W-1:0] r_f_q;
    logic                  r_f_oor;
    logic [RCP_W-1:0]      r_f_rcp;

    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            for (int c = 0; c < 3; c++) begin
                r_f_q[c] <= n_pe[c][RCP_SH +: QUO_W];
            end
            r_f_oor <= r_e_oor;
            r_f_rcp <= r_e_rcp;
        end
    end

    logic [2:0][QUO_W+RCP_W-1:0] n_pf;
    t_out_item                   n_out;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_pf[c] = (QUO_W+RCP_W)'(r_f_q[c]) * (QUO_W+RCP_W)'(r_f_rcp);
        end
        n_out.red          = r_f_oor ? '0 : n_pf[0][RCP_SH +: CH_W];
        n_out.green        = r_f_oor ? '0 : n_pf[1][RCP_SH +: CH_W];
        n_out.blue         = r_f_oor ? '0 : n_pf[2][RCP_SH +: CH_W];
        n_out.out_of_range = r_f_oor;
    end

    // Stage G: output register.
    t_out_item r_g_out;

    always_ff @(posedge i_clk) begin
        if (rdy_g) begin
            r_g_out <= n_out;
        end
    end

    assign o_valid = r_v_g;
    assign o_data  = r_g_out;

    `BLS_ASSERT(a_d_moves_to_e, i_clk, i_rst_n, (r_v_d && rdy_e) |=> r_v_e)
    `BLS_ASSERT(a_f_moves_to_g, i_clk, i_rst_n, (r_v_f && rdy_g) |=> r_v_g)
    `BLS_NEVER(a_oor_colour, i_clk, i_rst_n,
        r_v_g && r_g_out.out_of_range && ((r_g_out.red | r_g_out.green | r_g_out.blue) != '0))

endmodule
`default_nettype wire

// File: design/bilinear_rgb_frame_scaler_top.sv
// Top level of the bilinear RGB888 frame scaler.
`default_nettype none
// The scaler keeps a source frame of SRC_WIDTH by SRC_HEIGHT RGB888 pixels in four
// parity banks (even or odd column by even or odd row), so the four neighbours of any
// source position come out of one read of each bank in the same cycle. A write beat
// stores one source pixel; a compute beat names a destination pixel and yields one
// result beat carrying its bilinearly interpolated colour, or the out-of-range flag with
// black when the destination lies outside the configured size. The block takes one
// beat per clock while nothing stalls, writes and computes mixed freely, and a result
// moves through stages A to G, the last of them the output register; the depth of this
// pipeline is set by the reciprocal multiplications that replace both divisions
// (position by the multiplier, colour sum by the multiplier squared) and by
// the registered bank read. Back-pressure on the output stops only the stages that are
// full, so bubbles close up and input beats keep flowing until the pipeline is really
// full. Writes pass through the same stages and reach the store in order with compute
// reads, so a compute beat sees every write accepted before it. The store is not
// cleared after reset: reading a pixel that was never written gives an undefined
// colour. The ratio and size registers may only be changed while no beat is in flight.
module bilinear_rgb_frame_scaler_top #(
    parameter int SRC_WIDTH  = 256,
    parameter int SRC_HEIGHT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bls_pkg::t_in_item             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bls_pkg::t_out_item            o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  bls_pkg::t_cfg_reg             i_cfg_index,
    input  logic [bls_pkg::DIM_W-1:0]     i_cfg_data
);
    import bls_pkg::*;

    localparam int AW = bank_bits(SRC_WIDTH) + bank_bits(SRC_HEIGHT);

    // Configuration registers; a write is always taken at once.
    logic [MUL_W-1:0] r_mult, r_div;
    logic [DIM_W-1:0] r_dst_w, r_dst_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult  <= RST_MULT;
            r_div   <= RST_DIV;
            r_dst_w <= RST_DST_W;
            r_dst_h <= RST_DST_H;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MULT:  r_mult  <= i_cfg_data[MUL_W-1:0];
                CFG_DIV:   r_div   <= i_cfg_data[MUL_W-1:0];
                CFG_DST_W: r_dst_w <= i_cfg_data;
                CFG_DST_H: r_dst_h <= i_cfg_data;
            endcase
        end
    end

    // Position, fraction and weight stages.
    logic                  crd_valid, blend_ready;
    t_blend_ctl            crd_ctl;
    logic [3:0][AW-1:0]    rd_addr;
    logic                  wr_en;
    logic [1:0]            wr_bank;
    logic [AW-1:0]         wr_addr;
    logic [RGB_W-1:0]      wr_data;
    logic [3:0][RGB_W-1:0] pix;

    bls_coord #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_mult    (r_mult),
        .i_div     (r_div),
        .i_dst_w   (r_dst_w),
        .i_dst_h   (r_dst_h),
        .o_valid   (crd_valid),
        .i_ready   (blend_ready),
        .o_ctl     (crd_ctl),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_bank (wr_bank),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Four parity banks; the read register loads together with the blend input stage.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        bls_ram #(
            .AW (AW),
            .DW (RGB_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en && (wr_bank == 2'(b))),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (blend_ready),
            .i_raddr (rd_addr[b]),
            .o_rdata (pix[b])
        );
    end

    // Weighted sum, the two divisions and the output register.
    bls_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (crd_valid),
        .o_ready (blend_ready),
        .i_ctl   (crd_ctl),
        .i_pix   (pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the bilinear RGB888 frame scaler.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bls_pkg::*;

    // The source frame is 256 by 256 pixels.
    localparam int unsigned FRAME_DIM = 256;
    // The ceiling on the run, in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // How long the receiver holds off when back-pressure is requested.
    localparam int unsigned HOLD_CYCLES = 200;
    // Cycles to let pass once the last result is in, covering the pipeline depth.
    localparam int unsigned SETTLE = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_reg   i_cfg_index;
    logic [DIM_W-1:0] i_cfg_data;

    bilinear_rgb_frame_scaler_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // A row of the directed table: the beat to send and, for the rows whose
    // answer is plain, the colour typed in by hand.
    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item colour;
    } t_table_row;

    // Shadow of the block: source frame, which entries hold data, and the
    // ratio and size registers.
    logic [RGB_W-1:0] frame_copy [FRAME_DIM*FRAME_DIM];
    bit               frame_filled [FRAME_DIM*FRAME_DIM];
    logic [MUL_W-1:0] ratio_mult;
    logic [MUL_W-1:0] ratio_div;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;

    t_out_item   pending_colours [$];
    t_table_row  directed [$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned beats_sent;
    bit          gaps_on;
    bit          hold_request;

    // The clock toggles every 2 ns, giving a 4 ns period.
    always #2 i_clk = ~i_clk;

    // The run is cut short if it ever exceeds the cycle ceiling.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The colour of a source pixel as the block sees it: anything beyond the
    // frame reads as black.
    function automatic logic [RGB_W-1:0] pixel_at(input int unsigned col, input int unsigned row);
        if (col >= FRAME_DIM || row >= FRAME_DIM)
            return '0;
        return frame_copy[row*FRAME_DIM + col];
    endfunction

    // A zero in either ratio register behaves as one.
    function automatic int unsigned eff_mult();
        return (ratio_mult == 0) ? 1 : 32'(ratio_mult);
    endfunction

    function automatic int unsigned eff_div();
        return (ratio_div == 0) ? 1 : 32'(ratio_div);
    endfunction

    // The source position that a destination coordinate falls on, rounded down.
    function automatic int unsigned src_base(input int unsigned dst);
        return (dst * eff_div()) / eff_mult();
    endfunction

    // The interpolated colour of one destination pixel, computed exactly in
    // integers: four neighbours weighted by their distance, divided by m
    // squared and rounded down.
    function automatic t_out_item blend_pixel(input t_in_item beat);
        int unsigned m, x, y, xb, yb, fx, fy, wl, wr, wt, wb, acc;
        int unsigned w [4];
        logic [RGB_W-1:0] nb [4];
        logic [CH_W-1:0] ch [3];
        t_out_item res;
        res = '0;
        x = 32'(beat.dst_col);
        y = 32'(beat.dst_row);
        if (x >= frame_w || y >= frame_h) begin
            res.out_of_range = 1'b1;
            return res;
        end
        m  = eff_mult();
        xb = src_base(x);
        yb = src_base(y);
        fx = (x * eff_div()) % m;
        fy = (y * eff_div()) % m;
        wl = m - fx;
        wt = m - fy;
        // The last destination column and row lose their far neighbours.
        wr = (x + 1 == frame_w) ? 0 : fx;
        wb = (y + 1 == frame_h) ? 0 : fy;
        nb[0] = pixel_at(xb, yb);
        nb[1] = pixel_at(xb + 1, yb);
        nb[2] = pixel_at(xb, yb + 1);
        nb[3] = pixel_at(xb + 1, yb + 1);
        w[0] = wl * wt;
        w[1] = wr * wt;
        w[2] = wl * wb;
        w[3] = wr * wb;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += ((nb[k] >> (8*c)) & 8'hFF) * w[k];
            ch[c] = CH_W'(acc / (m * m));
        end
        res.red   = ch[0];
        res.green = ch[1];
        res.blue  = ch[2];
        return res;
    endfunction

    function automatic t_in_item pixel_write(input int unsigned col, input int unsigned row,
                                             input logic [RGB_W-1:0] rgb);
        t_in_item b;
        b = '0;
        b.kind    = KIND_WRITE;
        b.src_col = SRC_W'(col);
        b.src_row = SRC_W'(row);
        b.src_rgb = rgb;
        return b;
    endfunction

    function automatic t_in_item pixel_query(input int unsigned col, input int unsigned row);
        t_in_item b;
        b = '0;
        b.kind    = KIND_COMPUTE;
        b.dst_col = DST_W'(col);
        b.dst_row = DST_W'(row);
        // Idle fields carry noise so that the block is seen to ignore them.
        b.src_col = SRC_W'($urandom);
        b.src_row = SRC_W'($urandom);
        b.src_rgb = RGB_W'($urandom);
        return b;
    endfunction

    // Offers one beat on the input channel and waits for it to be taken. The
    // shadow frame is updated, and the expected colour queued, as it goes in.
    task automatic offer_beat(input t_in_item beat, input bit typed, input t_out_item colour);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = beat;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
        if (beat.kind == KIND_WRITE) begin
            frame_copy[beat.src_row*FRAME_DIM + beat.src_col]   = beat.src_rgb;
            frame_filled[beat.src_row*FRAME_DIM + beat.src_col] = 1'b1;
        end else begin
            pending_colours.push_back(typed ? colour : blend_pixel(beat));
        end
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Sends a compute beat, first filling any of its four neighbours inside
    // the frame that has never been written, since those read back undefined.
    task automatic query_pixel(input t_in_item beat, input bit typed, input t_out_item colour);
        int unsigned xb, yb, c, r;
        xb = src_base(32'(beat.dst_col));
        yb = src_base(32'(beat.dst_row));
        for (int k = 0; k < 4; k++) begin
            c = xb + (k % 2);
            r = yb + (k / 2);
            if (c < FRAME_DIM && r < FRAME_DIM && !frame_filled[r*FRAME_DIM + c])
                offer_beat(pixel_write(c, r, RGB_W'($urandom)), 1'b0, '0);
        end
        offer_beat(beat, typed, colour);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [DIM_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MULT:  ratio_mult = value[MUL_W-1:0];
            CFG_DIV:   ratio_div  = value[MUL_W-1:0];
            CFG_DST_W: frame_w    = value;
            CFG_DST_H: frame_h    = value;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits for every expected colour, then lets the pipeline settle.
    task automatic drain();
        wait (pending_colours.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // A random destination coordinate along one axis: mostly inside the
    // frame, often on its edges, and now and then anywhere at all.
    function automatic int unsigned pick_coord(input logic [DIM_W-1:0] size);
        int unsigned lim;
        lim = (size == 0) ? 1 : ((size > 4096) ? 4096 : 32'(size));
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 4095);
            1:       return (size == 0) ? 0 : ((size - 1) & 12'hFFF);
            2:       return 32'(size & 13'hFFF);
            default: return $urandom_range(0, lim - 1);
        endcase
    endfunction

    // The receiver takes results in bursts with random holds, and once holds
    // off for a long stretch so that the pipeline fills and stalls the input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Every result beat is held against the oldest expected colour.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_colours.size() == 0) begin
                $error("result beat with no colour expected");
                fail_count++;
            end else begin
                t_out_item want;
                want = pending_colours.pop_front();
                if (o_data.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_data.red);
                    fail_count++;
                end
                if (o_data.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_data.green);
                    fail_count++;
                end
                if (o_data.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_data.blue);
                    fail_count++;
                end
                if (o_data.out_of_range !== want.out_of_range) begin
                    $error("out_of_range: expected %0d, got %0d",
                           want.out_of_range, o_data.out_of_range);
                    fail_count++;
                end
            end
        end
    end

    // Directed rows, run under the reset settings (ratio 2/1, 512 by 480).
    // Typed colours: an exact source position returns its pixel unchanged,
    // and a destination beyond the frame gives black with the flag set.
    function automatic void add_row(input t_in_item beat, input bit typed, input t_out_item colour);
        t_table_row row;
        row.beat   = beat;
        row.typed  = typed;
        row.colour = colour;
        directed.push_back(row);
    endfunction

    function automatic void build_table();
        add_row(pixel_write(0, 0, 24'hFFFFFF), 1'b0, '0);
        add_row(pixel_write(1, 0, 24'h000000), 1'b0, '0);
        add_row(pixel_write(0, 1, 24'h00FF00), 1'b0, '0);
        add_row(pixel_write(1, 1, 24'hFFFFFF), 1'b0, '0);
        add_row(pixel_query(0, 0), 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0});
        add_row(pixel_query(1, 1), 1'b0, '0);
        add_row(pixel_query(1, 0), 1'b0, '0);
        add_row(pixel_write(255, 255, 24'hABCDEF), 1'b0, '0);
        add_row(pixel_write(254, 255, 24'h123456), 1'b0, '0);
        add_row(pixel_write(200, 100, 24'h00FF00), 1'b0, '0);
        // The last column and last row drop their far neighbours.
        add_row(pixel_query(511, 0), 1'b0, '0);
        add_row(pixel_query(0, 479), 1'b0, '0);
        add_row(pixel_query(511, 479), 1'b0, '0);
        add_row(pixel_query(509, 478), 1'b0, '0);
        add_row(pixel_query(401, 201), 1'b0, '0);
        // A neighbour past the right frame edge reads black.
        add_row(pixel_query(510, 300), 1'b0, '0);
        // Destinations beyond the configured size.
        add_row(pixel_query(512, 0), 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1});
        add_row(pixel_query(0, 480), 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1});
        add_row(pixel_query(4095, 4095), 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1});
        add_row(pixel_write(255, 0, 24'hFFFFFF), 1'b0, '0);
        add_row(pixel_query(510, 1), 1'b0, '0);
    endfunction

    // Settings for the random phases: multiplier, divisor, width, height. They
    // take in the zero ratio, the widest fields, a one-pixel frame and an
    // empty one.
    localparam int unsigned N_PHASES = 8;
    localparam logic [DIM_W-1:0] PHASE_CFG [N_PHASES][4] = '{
        '{13'd16, 13'd1,  13'd4096, 13'd4096},
        '{13'd3,  13'd2,  13'd300,  13'd200},
        '{13'd1,  13'd16, 13'd64,   13'd32},
        '{13'd0,  13'd0,  13'd8191, 13'd100},
        '{13'd31, 13'd31, 13'd1,    13'd1},
        '{13'd5,  13'd3,  13'd0,    13'd10},
        '{13'd16, 13'd16, 13'd256,  13'd8191},
        '{13'd7,  13'd5,  13'd640,  13'd480}
    };
    // Input beats per phase, counting the writes that fill unwritten neighbours.
    localparam int unsigned PHASE_BEATS = 85;

    initial begin
        int unsigned phase_start;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_ready      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_MULT;
        i_cfg_data   = '0;
        fail_count   = 0;
        cycle_count  = 0;
        beats_sent   = 0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        ratio_mult   = RST_MULT;
        ratio_div    = RST_DIV;
        frame_w      = RST_DST_W;
        frame_h      = RST_DST_H;
        foreach (frame_filled[i]) frame_filled[i] = 1'b0;
        build_table();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].beat.kind == KIND_WRITE)
                offer_beat(directed[i].beat, 1'b0, '0);
            else
                query_pixel(directed[i].beat, directed[i].typed, directed[i].colour);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_reg(CFG_MULT,  PHASE_CFG[p][0]);
            write_reg(CFG_DIV,   PHASE_CFG[p][1]);
            write_reg(CFG_DST_W, PHASE_CFG[p][2]);
            write_reg(CFG_DST_H, PHASE_CFG[p][3]);
            // The closing phase runs flat out on both sides.
            if (p == N_PHASES - 1)
                gaps_on = 1'b0;
            phase_start = beats_sent;
            // Early on the receiver stops for a long while mid-phase.
            for (int n = 0; beats_sent - phase_start < PHASE_BEATS; n++) begin
                if (p == 0 && n == 10)
                    hold_request = 1'b1;
                if ($urandom_range(0, 9) < 4)
                    offer_beat(pixel_write($urandom_range(0, 255), $urandom_range(0, 255),
                                           RGB_W'($urandom)), 1'b0, '0);
                else
                    query_pixel(pixel_query(pick_coord(frame_w), pick_coord(frame_h)),
                                1'b0, '0);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
